/* rtl/ppwc_pkg.sv */
// ppwc_pkg: shared types, widths and codes of the pulse period/width capture block
// no dependencies; used by the channel interfaces, the capture core and the top level
package ppwc_pkg;

    // counter and prescaler widths
    localparam int COUNT_BITS    = 32;
    localparam int PRESCALE_BITS = 16;

    // fixed field widths
    localparam int FUNC_BITS     = 3;
    localparam int FLAG_BITS     = 3;
    localparam int VALUE_BITS    = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [PRESCALE_BITS-1:0] presc_t;
    typedef logic [FLAG_BITS-1:0]     flags_t;
    typedef logic [VALUE_BITS-1:0]    value_t;
    typedef logic [APB_DATA_BITS-1:0] apb_data_t;
    typedef logic [APB_ADDR_BITS-1:0] apb_addr_t;

    localparam count_t COUNT_MAX = '1;

    // flag and enable bit positions
    localparam int FLAG_PERIOD = 0;
    localparam int FLAG_WIDTH  = 1;
    localparam int FLAG_OVF    = 2;

    // command codes
    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TICK      = 3'd0,
        FUNC_START     = 3'd1,
        FUNC_STOP      = 3'd2,
        FUNC_WRITE_EN  = 3'd3,
        FUNC_CLR_FLAGS = 3'd4
    } func_t;

    // register index (byte address bits 3:2)
    typedef enum logic [1:0] {
        REG_PRESCALE_DIV = 2'd0,
        REG_PERIOD_LIMIT = 2'd1,
        REG_ACTIVE_LOW   = 2'd2,
        REG_INPUT_SELECT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        presc_t prescale_div;
        count_t period_limit;
        logic   active_low;
        logic   input_select;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 pin_a;
        logic                 pin_b;
        logic [FLAG_BITS-1:0] enable_bits;
    } in_item_t;

    typedef struct packed {
        value_t period_value;
        value_t width_value;
        logic   period_flag;
        logic   width_flag;
        logic   overflow_flag;
        logic   period_event;
        logic   width_event;
        logic   overflow_event;
        logic   irq;
    } out_item_t;

endpackage

/* rtl/ppwc_if.sv */
// ppwc_if: valid/ready channel interfaces for input words and result words
// depends on ppwc_pkg for the payload structs
interface ppwc_in_if;
    logic               valid;
    logic               ready;
    ppwc_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppwc_out_if;
    logic                valid;
    logic                ready;
    ppwc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pulse_period_width_capture.sv */
// pulse_period_width_capture: input capture timer measuring pulse period and active width
// output: a result word is registered and valid in the cycle after its input word is accepted
// throughput: one word per cycle; the result register frees itself when taken,
// so the input stays ready as long as the result is drained each cycle
// reset: rst_n asynchronous, clears configuration, counters, captures, flags and enables
module pulse_period_width_capture (
    input  logic                clk,
    input  logic                rst_n,
    ppwc_in_if.sink             in_ch,
    ppwc_out_if.source          out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  ppwc_pkg::apb_addr_t paddr,
    input  ppwc_pkg::apb_data_t pwdata,
    output ppwc_pkg::apb_data_t prdata,
    output logic                pready
);

    // configuration registers, written through the apb port
    ppwc_pkg::presc_t prescale_div_reg;
    ppwc_pkg::count_t period_limit_reg;
    logic             active_low_reg;
    logic             input_select_reg;
    ppwc_pkg::cfg_t   cfg;

    // result register: parts the input side from the output side
    logic                out_valid_reg;
    ppwc_pkg::out_item_t out_data_reg;

    ppwc_pkg::out_item_t result;
    ppwc_pkg::reg_idx_t  reg_idx;
    logic                in_accept;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = ppwc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    // register file: word address in paddr[3:2], byte bits ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_div_reg <= '0;
            period_limit_reg <= '0;
            active_low_reg   <= 1'b0;
            input_select_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                ppwc_pkg::REG_PRESCALE_DIV: prescale_div_reg <= ppwc_pkg::presc_t'(pwdata);
                ppwc_pkg::REG_PERIOD_LIMIT: period_limit_reg <= ppwc_pkg::count_t'(pwdata);
                ppwc_pkg::REG_ACTIVE_LOW:   active_low_reg   <= pwdata[0];
                ppwc_pkg::REG_INPUT_SELECT: input_select_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (reg_idx)
            ppwc_pkg::REG_PRESCALE_DIV: prdata = ppwc_pkg::apb_data_t'(prescale_div_reg);
            ppwc_pkg::REG_PERIOD_LIMIT: prdata = ppwc_pkg::apb_data_t'(period_limit_reg);
            ppwc_pkg::REG_ACTIVE_LOW:   prdata = ppwc_pkg::apb_data_t'(active_low_reg);
            ppwc_pkg::REG_INPUT_SELECT: prdata = ppwc_pkg::apb_data_t'(input_select_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.prescale_div = prescale_div_reg;
    assign cfg.period_limit = period_limit_reg;
    assign cfg.active_low   = active_low_reg;
    assign cfg.input_select = input_select_reg;

    // take a new word when the result register is empty or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // state update and result for the word at the input, committed on accept
    ppwc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (in_accept),
        .item   (in_ch.data),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // an accepted word always shows up as a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
    else $error("accepted word produced no result");

    // a held result must never be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while result is stalled");

    // an event only fires from a pending flag, and irq tracks the events
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!out_data_reg.period_event || out_data_reg.period_flag)
            && (!out_data_reg.width_event || out_data_reg.width_flag)
            && (!out_data_reg.overflow_event || out_data_reg.overflow_flag)))
    else $error("event without its pending flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.irq == (out_data_reg.period_event
            || out_data_reg.width_event || out_data_reg.overflow_event)))
    else $error("irq does not match the fired events");

endmodule

/* rtl/ppwc_core.sv */
// ppwc_core: capture state registers and the single-pass update for one input word
// depends on ppwc_pkg
module ppwc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  ppwc_pkg::cfg_t      cfg,
    input  logic                accept,
    input  ppwc_pkg::in_item_t  item,
    output ppwc_pkg::out_item_t result
);

    ppwc_pkg::presc_t prescale_count_reg, prescale_count_next;
    ppwc_pkg::count_t main_count_reg, main_count_next;
    logic             last_level_reg, last_level_next;
    ppwc_pkg::count_t period_store_reg, period_store_next;
    ppwc_pkg::count_t width_store_reg, width_store_next;
    ppwc_pkg::flags_t pending_flags_reg, pending_flags_next;
    ppwc_pkg::flags_t notify_enables_reg, notify_enables_next;
    logic             running_reg, running_next;

    ppwc_pkg::flags_t flags_mid;
    ppwc_pkg::flags_t events;
    ppwc_pkg::count_t limit;
    logic             level;
    logic             rise;
    logic             fall;
    logic             act_edge;
    logic             idle_edge;

    assign level     = cfg.input_select ? item.pin_b : item.pin_a;
    assign rise      = !last_level_reg && level;
    assign fall      = last_level_reg && !level;
    assign act_edge  = cfg.active_low ? fall : rise;
    assign idle_edge = cfg.active_low ? rise : fall;
    assign limit     = (cfg.period_limit == '0) ? ppwc_pkg::COUNT_MAX : cfg.period_limit;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        main_count_next     = main_count_reg;
        last_level_next     = last_level_reg;
        period_store_next   = period_store_reg;
        width_store_next    = width_store_reg;
        flags_mid           = pending_flags_reg;
        notify_enables_next = notify_enables_reg;
        running_next        = running_reg;

        unique case (item.func)
            ppwc_pkg::FUNC_TICK:
            begin
                last_level_next = level;
                if (running_reg)
                begin
                    if (act_edge)
                    begin
                        period_store_next               = main_count_reg;
                        flags_mid[ppwc_pkg::FLAG_PERIOD] = 1'b1;
                        main_count_next                 = '0;
                        prescale_count_next             = '0;
                    end
                    else
                    begin
                        if (idle_edge)
                        begin
                            width_store_next                = main_count_reg;
                            flags_mid[ppwc_pkg::FLAG_WIDTH] = 1'b1;
                        end
                        if (prescale_count_reg >= cfg.prescale_div)
                        begin
                            prescale_count_next = '0;
                            if (main_count_reg >= limit)
                            begin
                                main_count_next               = '0;
                                flags_mid[ppwc_pkg::FLAG_OVF] = 1'b1;
                            end
                            else
                            begin
                                main_count_next = main_count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            prescale_count_next = prescale_count_reg + 1'b1;
                        end
                    end
                end
            end
            ppwc_pkg::FUNC_START:
            begin
                main_count_next     = '0;
                prescale_count_next = '0;
                flags_mid           = '0;
                running_next        = 1'b1;
            end
            ppwc_pkg::FUNC_STOP:
            begin
                running_next        = 1'b0;
                notify_enables_next = '0;
            end
            ppwc_pkg::FUNC_WRITE_EN:
            begin
                if (notify_enables_reg == '0)
                begin
                    flags_mid           = '0;
                    notify_enables_next = item.enable_bits;
                end
            end
            ppwc_pkg::FUNC_CLR_FLAGS:
            begin
                flags_mid = '0;
            end
            default:
            begin
            end
        endcase

        // enabled flags fire and are consumed
        events             = flags_mid & notify_enables_next;
        pending_flags_next = flags_mid & ~events;
    end

    always_comb
    begin
        result.period_value   = ppwc_pkg::value_t'(period_store_next);
        result.width_value    = ppwc_pkg::value_t'(width_store_next);
        result.period_flag    = flags_mid[ppwc_pkg::FLAG_PERIOD];
        result.width_flag     = flags_mid[ppwc_pkg::FLAG_WIDTH];
        result.overflow_flag  = flags_mid[ppwc_pkg::FLAG_OVF];
        result.period_event   = events[ppwc_pkg::FLAG_PERIOD];
        result.width_event    = events[ppwc_pkg::FLAG_WIDTH];
        result.overflow_event = events[ppwc_pkg::FLAG_OVF];
        result.irq            = |events;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            main_count_reg     <= '0;
            last_level_reg     <= 1'b0;
            period_store_reg   <= '0;
            width_store_reg    <= '0;
            pending_flags_reg  <= '0;
            notify_enables_reg <= '0;
            running_reg        <= 1'b0;
        end
        else if (accept)
        begin
            prescale_count_reg <= prescale_count_next;
            main_count_reg     <= main_count_next;
            last_level_reg     <= last_level_next;
            period_store_reg   <= period_store_next;
            width_store_reg    <= width_store_next;
            pending_flags_reg  <= pending_flags_next;
            notify_enables_reg <= notify_enables_next;
            running_reg        <= running_next;
        end
    end

endmodule
